// ----- rtl/link_ping_loss_monitor_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the link ping and loss monitor.
// ----------------------------------------------------------------------------
`ifndef LINK_PING_LOSS_MONITOR_MACROS_SVH
`define LINK_PING_LOSS_MONITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPLM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPLM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lplm_pkg.sv -----
// ----------------------------------------------------------------------------
// lplm_pkg
// Shared constants, types and helpers of the link ping and loss monitor.
// ----------------------------------------------------------------------------
package lplm_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int LINKS        = 256;

   localparam int WIN_W       = $clog2(WINDOW_DEPTH);
   localparam int FILL_W      = WIN_W + 1;
   localparam int LINK_W      = $clog2(LINKS);
   localparam int SAMP_ADDR_W = LINK_W + WIN_W;
   localparam int SAMP_DEPTH  = LINKS * (2 ** WIN_W);

   localparam int PING_W    = 16;
   localparam int LOSS_W    = 7;
   localparam int CNT_W     = 32;
   localparam int WIN_REG_W = 7;
   localparam int PSUM_W    = PING_W + WIN_W;
   localparam int LSUM_W    = LOSS_W + WIN_W;

   localparam int DIV_D_W   = CNT_W;
   localparam int DIV_N_W   = CNT_W + 7;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   localparam int PCT_SCALE = 100;
   localparam int LOSS_CAP  = 100;

   // Configuration register indexes.
   localparam logic CSR_PING_WIN = 1'b0;
   localparam logic CSR_LOSS_WIN = 1'b1;

   typedef enum logic [1:0] {
      CMD_PING  = 2'd0,
      CMD_LOSS  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   // Per-link statistics record held in the link memory.
   typedef struct packed {
      logic [FILL_W-1:0] ping_fill;
      logic [WIN_W-1:0]  ping_head;
      logic [FILL_W-1:0] loss_fill;
      logic [WIN_W-1:0]  loss_head;
      logic [PING_W-1:0] avg_ping;
      logic [PING_W-1:0] jitter;
      logic [LOSS_W-1:0] avg_loss;
      logic [LOSS_W-1:0] pending;
      logic [CNT_W-1:0]  prev_drop;
      logic [CNT_W-1:0]  prev_sent;
   } link_rec_type;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // A window of zero acts as one, a window beyond the depth acts as the depth.
   function automatic logic [FILL_W-1:0] eff_window(input logic [WIN_REG_W-1:0] w);
      logic [FILL_W-1:0] r;
      if (w == '0) begin
         r = FILL_W'(1);
      end else if (int'(w) > WINDOW_DEPTH) begin
         r = FILL_W'(WINDOW_DEPTH);
      end else begin
         r = FILL_W'(w);
      end
      return r;
   endfunction

endpackage

// ----- rtl/lplm_ram.sv -----
// ----------------------------------------------------------------------------
// lplm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lplm_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/lplm_div.sv -----
// ----------------------------------------------------------------------------
// lplm_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lplm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lplm_pkg::DIV_N_W-1:0]   dividend,
   input  logic [lplm_pkg::DIV_D_W-1:0]   divisor,
   output logic [lplm_pkg::DIV_N_W-1:0]   quotient,
   output lplm_pkg::div_stat_type         stat
);
   import lplm_pkg::*;

   logic [DIV_N_W-1:0]   q_ff;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_D_W:0]     rem_s;
   logic [DIV_D_W:0]     rem_d;
   logic                 ge;

   // One trial subtraction per step.
   always_comb begin
      rem_s = {rem_ff, q_ff[DIV_N_W-1]};
      rem_d = rem_s - {1'b0, dvs_ff};
      ge    = (rem_s >= {1'b0, dvs_ff});
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_N_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: partial remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DIV_N_W-2:0], ge};
         rem_ff <= ge ? rem_d[DIV_D_W-1:0] : rem_s[DIV_D_W-1:0];
      end
   end

   assign quotient  = q_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/link_ping_loss_monitor.sv -----
// ----------------------------------------------------------------------------
// link_ping_loss_monitor
// Per-link ping average, ping jitter and packet loss average over windows.
//
//   Channel  Direction  Contents
//   req_     in         tuser: cmd; tdata: client_id, round_trip_ms,
//                       drop_total, sent_total
//   rsp_     out        tdata: mean_ping, ping_jitter, mean_loss,
//                       ping_ready, loss_ready
//   csr_     in         write enable, register index, write data
//
// A ping transaction whose window is not yet full goes from the link read
// straight to the write-back. A loss transaction divides for its loss
// percentage, and that is its only divide when its window is not full.
// A full window is walked through the sample memory one entry per cycle and
// two serial divides follow: the mean and the jitter for a ping, the mean and
// the percentage for a loss. A loss transaction with no packets sent since
// the previous one skips the percentage divide.
// Reset clears the link valid bits at once; there is no clearing pass.
// A result waiting on rsp_tready holds the next transaction in its last state.
// ----------------------------------------------------------------------------
`include "link_ping_loss_monitor_macros.svh"

module link_ping_loss_monitor (
   input  logic                           clock,
   input  logic                           reset,
   // cmd[1:0]
   input  logic [1:0]                     req_tuser,
   // client_id[7:0], round_trip_ms[23:8], drop_total[55:24], sent_total[87:56]
   input  logic [87:0]                    req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mean_ping[15:0], ping_jitter[31:16], mean_loss[38:32],
   // ping_ready[39], loss_ready[40], zero fill above
   output logic [47:0]                    rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_we,
   input  logic                           csr_addr,
   input  logic [lplm_pkg::WIN_REG_W-1:0] csr_wdata
);
   import lplm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LREAD = 5'b00010,
      S_WALK  = 5'b00100,
      S_DIV   = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   localparam int REC_W = $bits(link_rec_type);

   state_type           state_ff, state_in;
   logic [WIN_REG_W-1:0] ping_win_ff, loss_win_ff;
   logic [FILL_W-1:0]   wp, wl;

   cmd_type             cmd_ff, cmd_in;
   logic [7:0]          id_ff, id_in;
   logic [PING_W-1:0]   rtt_ff, rtt_in;
   logic [CNT_W-1:0]    drop_ff, drop_in, sent_ff, sent_in;
   logic [CNT_W-1:0]    drops_ff, drops_in, sentd_ff, sentd_in;

   link_rec_type        rec_ff, rec_in, lk_rd, rec_new;
   logic [REC_W-1:0]    lk_q;
   logic [LINKS-1:0]    valid_ff;
   logic                lk_vld_ff;
   logic                full_ff, full_in;

   logic [FILL_W-1:0]   k_iss_ff, k_iss_in, k_rcv_ff, k_rcv_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [PSUM_W-1:0]   psum_ff, psum_in, pfl_ff, pfl_in;
   logic [PING_W-1:0]   last_ff, last_in, pdiff;
   logic [LSUM_W-1:0]   lsum_ff, lsum_in;
   logic [LOSS_W-1:0]   pct_ff, pct_in;
   logic                ph_ff, ph_in, start_ff, start_in;

   logic [FILL_W-1:0]   wf;
   logic [WIN_W-1:0]    whead, walk_pos;
   logic [FILL_W:0]     pos_raw;
   logic [PING_W-1:0]   ping_q;
   logic [LOSS_W-1:0]   loss_q;

   logic                div_start;
   logic [DIV_N_W-1:0]  div_dvd, div_quo;
   logic [DIV_D_W-1:0]  div_dvs;
   div_stat_type        div_stat;

   logic                req_fire, fin_go;
   logic                rsp_vld_ff;
   logic [47:0]         rsp_data_ff;

   assign wp         = eff_window(ping_win_ff);
   assign wl         = eff_window(loss_win_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign lk_rd      = lk_vld_ff ? link_rec_type'(lk_q) : '0;

   // Walk position: k-th newest entry behind the head.
   assign wf       = (cmd_ff == CMD_PING) ? rec_ff.ping_fill : rec_ff.loss_fill;
   assign whead    = (cmd_ff == CMD_PING) ? rec_ff.ping_head : rec_ff.loss_head;
   assign pos_raw  = (FILL_W + 1)'(whead) + (FILL_W + 1)'(WINDOW_DEPTH - 1)
                     - (FILL_W + 1)'(k_iss_ff);
   assign walk_pos = (int'(pos_raw) >= WINDOW_DEPTH)
                     ? WIN_W'(pos_raw - (FILL_W + 1)'(WINDOW_DEPTH))
                     : WIN_W'(pos_raw);
   assign pdiff    = (ping_q > last_ff) ? (ping_q - last_ff) : (last_ff - ping_q);

   // Memories: link records and the two sample rings.
   lplm_ram #(.WIDTH(REC_W), .DEPTH(LINKS)) u_link_ram (
      .clock (clock),
      .we    (fin_go),
      .waddr (id_ff[LINK_W-1:0]),
      .wdata (rec_new),
      .raddr (req_tdata[LINK_W-1:0]),
      .rdata (lk_q)
   );

   lplm_ram #(.WIDTH(PING_W), .DEPTH(SAMP_DEPTH)) u_ping_ram (
      .clock (clock),
      .we    (fin_go && (cmd_ff == CMD_PING)),
      .waddr ({id_ff[LINK_W-1:0], rec_ff.ping_head}),
      .wdata (rtt_ff),
      .raddr ({id_ff[LINK_W-1:0], walk_pos}),
      .rdata (ping_q)
   );

   lplm_ram #(.WIDTH(LOSS_W), .DEPTH(SAMP_DEPTH)) u_loss_ram (
      .clock (clock),
      .we    (fin_go && (cmd_ff == CMD_LOSS)),
      .waddr ({id_ff[LINK_W-1:0], rec_ff.loss_head}),
      .wdata (rec_ff.pending),
      .raddr ({id_ff[LINK_W-1:0], walk_pos}),
      .rdata (loss_q)
   );

   lplm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // Record written back at the end of a transaction.
   always_comb begin
      rec_new = rec_ff;
      case (cmd_ff)
         CMD_PING: begin
            rec_new.ping_fill = (full_ff ? (wp - FILL_W'(1)) : rec_ff.ping_fill)
                                + FILL_W'(1);
            rec_new.ping_head = (int'(rec_ff.ping_head) == WINDOW_DEPTH - 1)
                                ? '0 : rec_ff.ping_head + WIN_W'(1);
         end
         CMD_LOSS: begin
            rec_new.loss_fill = (full_ff ? (wl - FILL_W'(1)) : rec_ff.loss_fill)
                                + FILL_W'(1);
            rec_new.loss_head = (int'(rec_ff.loss_head) == WINDOW_DEPTH - 1)
                                ? '0 : rec_ff.loss_head + WIN_W'(1);
            rec_new.pending   = pct_ff;
            rec_new.prev_drop = drop_ff;
            rec_new.prev_sent = sent_ff;
         end
         CMD_CLEAR: begin
            rec_new = '0;
         end
         default: begin
            rec_new = rec_ff;
         end
      endcase
   end

   // Sequencer: read link, walk a full window, divide as needed, write back.
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      id_in     = id_ff;
      rtt_in    = rtt_ff;
      drop_in   = drop_ff;
      sent_in   = sent_ff;
      drops_in  = drops_ff;
      sentd_in  = sentd_ff;
      rec_in    = rec_ff;
      full_in   = full_ff;
      k_iss_in  = k_iss_ff;
      k_rcv_in  = k_rcv_ff;
      rd_vld_in = 1'b0;
      psum_in   = psum_ff;
      pfl_in    = pfl_ff;
      last_in   = last_ff;
      lsum_in   = lsum_ff;
      pct_in    = pct_ff;
      ph_in     = ph_ff;
      start_in  = start_ff;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      fin_go    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = cmd_type'(req_tuser);
               id_in    = req_tdata[7:0];
               rtt_in   = req_tdata[23:8];
               drop_in  = req_tdata[55:24];
               sent_in  = req_tdata[87:56];
               state_in = S_LREAD;
            end
         end
         S_LREAD: begin
            rec_in   = lk_rd;
            drops_in = drop_ff - lk_rd.prev_drop;
            sentd_in = sent_ff - lk_rd.prev_sent;
            k_iss_in = '0;
            k_rcv_in = '0;
            psum_in  = '0;
            pfl_in   = '0;
            last_in  = '0;
            lsum_in  = '0;
            pct_in   = '0;
            ph_in    = 1'b0;
            start_in = 1'b1;
            case (cmd_ff)
               CMD_PING: begin
                  full_in  = (lk_rd.ping_fill >= wp);
                  state_in = (lk_rd.ping_fill >= wp) ? S_WALK : S_FIN;
               end
               CMD_LOSS: begin
                  full_in  = (lk_rd.loss_fill >= wl);
                  ph_in    = !(lk_rd.loss_fill >= wl);
                  state_in = (lk_rd.loss_fill >= wl) ? S_WALK : S_DIV;
               end
               default: begin
                  full_in  = 1'b0;
                  state_in = S_FIN;
               end
            endcase
         end
         S_WALK: begin
            // Issue one read per cycle; the registered read port returns the data in the next cycle.
            if (k_iss_ff < wf) begin
               k_iss_in  = k_iss_ff + FILL_W'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               psum_in  = psum_ff + PSUM_W'(ping_q);
               if (last_ff != '0) begin
                  pfl_in = pfl_ff + PSUM_W'(pdiff);
               end
               last_in  = ping_q;
               lsum_in  = lsum_ff + LSUM_W'(loss_q);
               k_rcv_in = k_rcv_ff + FILL_W'(1);
               if (k_rcv_ff + FILL_W'(1) == wf) begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (start_ff) begin
               start_in = 1'b0;
               if (ph_ff && (cmd_ff == CMD_LOSS) && (sentd_ff == '0)) begin
                  pct_in   = '0;
                  state_in = S_FIN;
               end else begin
                  div_start = 1'b1;
                  if (!ph_ff) begin
                     div_dvd = (cmd_ff == CMD_PING) ? DIV_N_W'(psum_ff)
                                                    : DIV_N_W'(lsum_ff);
                     div_dvs = DIV_D_W'(wf);
                  end else if (cmd_ff == CMD_PING) begin
                     div_dvd = DIV_N_W'(pfl_ff);
                     div_dvs = DIV_D_W'(wf);
                  end else begin
                     div_dvd = DIV_N_W'(drops_ff) * DIV_N_W'(PCT_SCALE);
                     div_dvs = sentd_ff;
                  end
               end
            end else if (div_stat.done) begin
               if (!ph_ff) begin
                  if (cmd_ff == CMD_PING) begin
                     rec_in.avg_ping = div_quo[PING_W-1:0];
                  end else begin
                     rec_in.avg_loss = div_quo[LOSS_W-1:0];
                  end
                  ph_in    = 1'b1;
                  start_in = 1'b1;
               end else begin
                  if (cmd_ff == CMD_PING) begin
                     rec_in.jitter = div_quo[PING_W-1:0];
                  end else if (div_quo > DIV_N_W'(LOSS_CAP)) begin
                     pct_in = LOSS_W'(LOSS_CAP);
                  end else begin
                     pct_in = div_quo[LOSS_W-1:0];
                  end
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (!rsp_vld_ff || rsp_tready) begin
               fin_go   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ping_win_ff <= WIN_REG_W'(16);
         loss_win_ff <= WIN_REG_W'(8);
         valid_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         start_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         start_ff  <= start_in;
         if (csr_we && (csr_addr == CSR_PING_WIN)) begin
            ping_win_ff <= csr_wdata;
         end
         if (csr_we && (csr_addr == CSR_LOSS_WIN)) begin
            loss_win_ff <= csr_wdata;
         end
         if (fin_go) begin
            valid_ff[id_ff[LINK_W-1:0]] <= 1'b1;
         end
         if (fin_go) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      id_ff    <= id_in;
      rtt_ff   <= rtt_in;
      drop_ff  <= drop_in;
      sent_ff  <= sent_in;
      drops_ff <= drops_in;
      sentd_ff <= sentd_in;
      rec_ff   <= rec_in;
      full_ff  <= full_in;
      k_iss_ff <= k_iss_in;
      k_rcv_ff <= k_rcv_in;
      psum_ff  <= psum_in;
      pfl_ff   <= pfl_in;
      last_ff  <= last_in;
      lsum_ff  <= lsum_in;
      pct_ff   <= pct_in;
      ph_ff    <= ph_in;
      if (req_fire) begin
         lk_vld_ff <= valid_ff[req_tdata[LINK_W-1:0]];
      end
      if (fin_go) begin
         rsp_data_ff <= {7'b0, (rec_new.loss_fill >= wl), (rec_new.ping_fill >= wp),
                         rec_new.avg_loss, rec_new.jitter, rec_new.avg_ping};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Assertions.
   `LPLM_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
                    !req_tready, "input accepted while a transaction is in progress")
   `LPLM_ASSERT_IMP(a_loss_capped, clock, reset, rsp_tvalid,
                    rsp_tdata[38:32] <= 7'(LOSS_CAP), "mean loss above cap")
   `LPLM_ASSERT_IMP(a_div_in_div_state, clock, reset, div_stat.busy,
                    state_ff == S_DIV, "divider running outside the divide state")
   `LPLM_ASSERT_NXT(a_fin_shows_result, clock, reset, fin_go,
                    rsp_tvalid && (state_ff == S_IDLE), "write-back did not present a result")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Link ping and loss monitor testbench
// Drives ping, loss and clear transactions across several window settings,
// predicts each result from a behavioral model of the per-link statistics and
// compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import lplm_pkg::*;

   localparam int DEPTH = 64;
   localparam int NLINK = 256;
   localparam int SLOTS = 2048;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [87:0] data;
   } req_item_type;

   // Fields from the highest bit down; mean_ping sits in the lowest bits.
   typedef struct packed {
      logic        loss_rdy;
      logic        ping_rdy;
      logic [6:0]  mean_loss;
      logic [15:0] jitter;
      logic [15:0] mean_ping;
   } link_stat_type;

   logic        clock;
   logic        reset;
   logic [1:0]  req_tuser;
   logic [87:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_we;
   logic        csr_addr;
   logic [6:0]  csr_wdata;
   logic        req_acc;
   logic        rsp_acc;

   link_ping_loss_monitor u_dut (
      .clock(clock), .reset(reset),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Model state of every link.
   logic [15:0] m_ping_buf [NLINK*DEPTH];
   logic [6:0]  m_loss_buf [NLINK*DEPTH];
   int unsigned m_ping_fill [NLINK];
   int unsigned m_ping_head [NLINK];
   int unsigned m_loss_fill [NLINK];
   int unsigned m_loss_head [NLINK];
   logic [15:0] m_avg_ping [NLINK];
   logic [15:0] m_jitter [NLINK];
   logic [6:0]  m_avg_loss [NLINK];
   logic [6:0]  m_pending [NLINK];
   logic [31:0] m_prev_drop [NLINK];
   logic [31:0] m_prev_sent [NLINK];
   logic [6:0]  m_ping_win;
   logic [6:0]  m_loss_win;

   // Pending requests and expected results, each a ring with two counters.
   req_item_type  req_buf [SLOTS];
   int            req_head, req_tail;
   link_stat_type exp_buf [SLOTS];
   int            exp_head, exp_tail;
   int         errors;
   int         n_results;
   int         n_sent;
   int         hold_cycles;   // long receiver hold-off requested by stimulus
   int         n_ping, n_loss, n_clear, n_other;

   function automatic int unsigned win_of(logic [6:0] w);
      if (w == 0) return 1;
      if (w > DEPTH) return DEPTH;
      return w;
   endfunction

   function automatic int unsigned slot(int unsigned head, int unsigned k);
      return (head + DEPTH - (k % DEPTH) + DEPTH - 1) % DEPTH;
   endfunction

   function automatic void clear_stats(int c);
      m_ping_fill[c] = 0; m_ping_head[c] = 0;
      m_loss_fill[c] = 0; m_loss_head[c] = 0;
      m_avg_ping[c] = 0; m_jitter[c] = 0; m_avg_loss[c] = 0;
      m_pending[c] = 0; m_prev_drop[c] = 0; m_prev_sent[c] = 0;
   endfunction

   function automatic void queue_req(req_item_type it);
      req_buf[req_tail % SLOTS] = it;
      req_tail++;
   endfunction

   // Apply one accepted transaction to the model and return the link status.
   function automatic link_stat_type update_link_stats(req_item_type it);
      int unsigned c, w, fill, k, base;
      logic [31:0] sum, fl, last, v, drops, sent;
      logic [63:0] q;
      logic [6:0]  pct;
      link_stat_type r;
      c = it.data[7:0];
      base = c * DEPTH;
      case (it.cmd)
         CMD_PING: begin
            w = win_of(m_ping_win);
            fill = m_ping_fill[c];
            if (fill >= w) begin
               sum = 0; fl = 0; last = 0;
               for (k = 0; k < fill; k++) begin
                  v = m_ping_buf[base + slot(m_ping_head[c], k)];
                  sum += v;
                  // A pair is skipped when its newer sample is zero.
                  if (last != 0) fl += (v > last) ? v - last : last - v;
                  last = v;
               end
               m_avg_ping[c] = 16'(sum / fill);
               m_jitter[c] = 16'(fl / fill);
               fill = w - 1;
            end
            m_ping_buf[base + m_ping_head[c]] = it.data[23:8];
            m_ping_head[c] = (m_ping_head[c] + 1) % DEPTH;
            m_ping_fill[c] = fill + 1;
         end
         CMD_LOSS: begin
            w = win_of(m_loss_win);
            fill = m_loss_fill[c];
            if (fill >= w) begin
               sum = 0;
               for (k = 0; k < fill; k++)
                  sum += m_loss_buf[base + slot(m_loss_head[c], k)];
               m_avg_loss[c] = 7'(sum / fill);
               fill = w - 1;
            end
            drops = it.data[55:24] - m_prev_drop[c];
            sent = it.data[87:56] - m_prev_sent[c];
            if (sent != 0) begin
               q = (64'(drops) * 100) / 64'(sent);
               pct = (q > 100) ? 7'd100 : 7'(q);
            end else begin
               pct = '0;
            end
            // The loss percentage enters the window one sample late.
            m_loss_buf[base + m_loss_head[c]] = m_pending[c];
            m_loss_head[c] = (m_loss_head[c] + 1) % DEPTH;
            m_loss_fill[c] = fill + 1;
            m_pending[c] = pct;
            m_prev_drop[c] = it.data[55:24];
            m_prev_sent[c] = it.data[87:56];
         end
         CMD_CLEAR: begin
            clear_stats(c);
         end
         default: begin
         end
      endcase
      r.mean_ping = m_avg_ping[c];
      r.jitter = m_jitter[c];
      r.mean_loss = m_avg_loss[c];
      r.ping_rdy = m_ping_fill[c] >= win_of(m_ping_win);
      r.loss_rdy = m_loss_fill[c] >= win_of(m_loss_win);
      return r;
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: offers queued transactions with random gaps.
   int drv_gap;
   initial drv_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_acc) begin
         // Hold the offered transaction until it is taken.
      end else if (drv_gap > 0) begin
         drv_gap <= drv_gap - 1;
         req_tvalid <= 1'b0;
      end else if (req_tail != req_head) begin
         req_tuser <= req_buf[req_head % SLOTS].cmd;
         req_tdata <= req_buf[req_head % SLOTS].data;
         req_tvalid <= 1'b1;
         req_head <= req_head + 1;
         drv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver back-pressure: a fresh wait after each result plus the long hold-off.
   int rcv_gap;
   initial rcv_gap = 0;
   always @(negedge clock) begin
      int wait_draw;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_acc) begin
         wait_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (wait_draw > 0) begin
            rcv_gap <= wait_draw - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end else if (rcv_gap > 0) begin
         rcv_gap <= rcv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on accepted requests and checks accepted results.
   always @(posedge clock) begin
      link_stat_type got, exp_s;
      req_acc <= req_tvalid && req_tready;
      rsp_acc <= rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            exp_buf[exp_tail % SLOTS] = update_link_stats({req_tuser, req_tdata});
            exp_tail++;
            n_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[40:0];
            n_results++;
            if (rsp_tdata[47:41] != 0) begin
               $display("%0t: pad bits exp 0 got %h", $time, rsp_tdata[47:41]);
               errors++;
            end
            if (exp_tail == exp_head) begin
               $display("%0t: unexpected result exp none got %h", $time, got);
               errors++;
            end else begin
               exp_s = exp_buf[exp_head % SLOTS];
               exp_head++;
               if (got.mean_ping != exp_s.mean_ping) begin
                  $display("%0t: mean_ping exp %0d got %0d", $time,
                           exp_s.mean_ping, got.mean_ping);
                  errors++;
               end
               if (got.jitter != exp_s.jitter) begin
                  $display("%0t: ping_jitter exp %0d got %0d", $time,
                           exp_s.jitter, got.jitter);
                  errors++;
               end
               if (got.mean_loss != exp_s.mean_loss) begin
                  $display("%0t: mean_loss exp %0d got %0d", $time,
                           exp_s.mean_loss, got.mean_loss);
                  errors++;
               end
               if (got.ping_rdy != exp_s.ping_rdy) begin
                  $display("%0t: ping_ready exp %0d got %0d", $time,
                           exp_s.ping_rdy, got.ping_rdy);
                  errors++;
               end
               if (got.loss_rdy != exp_s.loss_rdy) begin
                  $display("%0t: loss_ready exp %0d got %0d", $time,
                           exp_s.loss_rdy, got.loss_rdy);
                  errors++;
               end
            end
         end
      end
   end

   function automatic req_item_type make_req(logic [1:0] cmd, logic [7:0] link,
                                             logic [15:0] rtt, logic [31:0] drop,
                                             logic [31:0] sent);
      req_item_type it;
      it.cmd = cmd;
      it.data = {sent, drop, rtt, link};
      case (cmd)
         CMD_PING: n_ping++;
         CMD_LOSS: n_loss++;
         CMD_CLEAR: n_clear++;
         default: n_other++;
      endcase
      return it;
   endfunction

   task automatic wait_idle();
      while (req_tail != req_head || req_tvalid || exp_tail != exp_head)
         @(posedge clock);
      // Let the block finish any trailing work before touching registers.
      repeat (200) @(posedge clock);
   endtask

   task automatic write_window(logic idx, logic [6:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      if (idx == CSR_PING_WIN) m_ping_win = val;
      else m_loss_win = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random phase: a few busy links with plausible counters plus noise.
   task automatic random_phase(int count);
      logic [31:0] drop_run [4];
      logic [31:0] sent_run [4];
      logic [7:0]  link;
      int i, pick, r;
      logic [31:0] d_inc, s_inc;
      for (i = 0; i < 4; i++) begin
         drop_run[i] = 0;
         sent_run[i] = 0;
      end
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 3);
         link = (pick == 3) ? 8'($urandom_range(0, 255)) : 8'(pick * 85);
         r = $urandom_range(0, 99);
         if (r < 55) begin
            // Ping samples: mostly realistic, sometimes zero or random over the full 16-bit range.
            case ($urandom_range(0, 9))
               0: queue_req(make_req(CMD_PING, link, 16'd0, 0, 0));
               1: queue_req(make_req(CMD_PING, link, 16'($urandom), 0, 0));
               default: queue_req(make_req(CMD_PING, link,
                                           16'($urandom_range(10, 400)), 0, 0));
            endcase
         end else if (r < 93) begin
            if (pick == 3) begin
               queue_req(make_req(CMD_LOSS, link, 16'($urandom),
                                  $urandom, $urandom));
            end else begin
               s_inc = $urandom_range(0, 200);
               d_inc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400)
                                                   : $urandom_range(0, 20);
               drop_run[pick] += d_inc;
               sent_run[pick] += s_inc;
               queue_req(make_req(CMD_LOSS, link, 16'($urandom),
                                  drop_run[pick], sent_run[pick]));
            end
         end else if (r < 97) begin
            queue_req(make_req(CMD_CLEAR, link, 16'($urandom),
                               $urandom, $urandom));
            if (pick != 3) begin
               drop_run[pick] = 0;
               sent_run[pick] = 0;
            end
         end else begin
            queue_req(make_req(CMD_UNUSED, link, 16'($urandom),
                               $urandom, $urandom));
         end
      end
   endtask

   initial begin
      int c;
      errors = 0; n_results = 0; n_sent = 0; hold_cycles = 0;
      n_ping = 0; n_loss = 0; n_clear = 0; n_other = 0;
      req_head = 0; req_tail = 0; exp_head = 0; exp_tail = 0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tuser = '0; req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0; csr_addr = 1'b0; csr_wdata = '0;
      for (c = 0; c < NLINK; c++) clear_stats(c);
      m_ping_win = 16;
      m_loss_win = 8;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: small windows, extremes of the fields and every command.
      write_window(CSR_PING_WIN, 7'd2);
      write_window(CSR_LOSS_WIN, 7'd1);
      queue_req(make_req(CMD_PING, 8'd255, 16'hFFFF, 0, 0));
      queue_req(make_req(CMD_PING, 8'd255, 16'd0, 0, 0));
      queue_req(make_req(CMD_PING, 8'd255, 16'hFFFF, 0, 0));
      queue_req(make_req(CMD_PING, 8'd255, 16'd1, 0, 0));
      queue_req(make_req(CMD_PING, 8'd0, 16'd100, 0, 0));
      queue_req(make_req(CMD_PING, 8'd0, 16'd300, 0, 0));
      queue_req(make_req(CMD_PING, 8'd0, 16'd50, 0, 0));
      // Loss: no packets sent, loss above 100 percent, counters wrapping.
      queue_req(make_req(CMD_LOSS, 8'd0, 0, 32'd5, 32'd0));
      queue_req(make_req(CMD_LOSS, 8'd0, 0, 32'd500, 32'd10));
      queue_req(make_req(CMD_LOSS, 8'd0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_req(make_req(CMD_LOSS, 8'd0, 0, 32'd3, 32'd9));
      queue_req(make_req(CMD_LOSS, 8'd0, 0, 32'hAAAA_AAAA, 32'h5555_5555));
      queue_req(make_req(CMD_LOSS, 8'd0, 0, 32'h5555_5555, 32'hAAAA_AAAA));
      queue_req(make_req(CMD_UNUSED, 8'd0, 16'h5A5A, 32'd1, 32'd1));
      queue_req(make_req(CMD_CLEAR, 8'd0, 0, 0, 0));
      queue_req(make_req(CMD_PING, 8'd0, 16'd7, 0, 0));
      queue_req(make_req(CMD_LOSS, 8'd0, 0, 32'd1, 32'd2));
      wait_idle();

      // Window registers at zero and above the depth.
      write_window(CSR_PING_WIN, 7'd0);
      write_window(CSR_LOSS_WIN, 7'd127);
      random_phase(150);
      // Long receiver hold-off while the sender keeps offering.
      hold_cycles = 3000;
      wait_idle();

      // Full-depth ping window, then shrink it while filled.
      write_window(CSR_PING_WIN, 7'd64);
      write_window(CSR_LOSS_WIN, 7'd64);
      random_phase(300);
      wait_idle();
      write_window(CSR_PING_WIN, 7'd3);
      write_window(CSR_LOSS_WIN, 7'd5);
      random_phase(300);
      wait_idle();
      write_window(CSR_PING_WIN, 7'd16);
      write_window(CSR_LOSS_WIN, 7'd8);
      random_phase(280);
      wait_idle();

      $display("Covered %0d pings, %0d loss samples, %0d clears, %0d unused cmds;",
               n_ping, n_loss, n_clear, n_other);
      $display("checked %0d results over several window settings.", n_results);
      if (errors == 0 && n_results == n_sent)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lplm_pkg.sv
rtl/lplm_ram.sv
rtl/lplm_div.sv
rtl/link_ping_loss_monitor.sv
tb/testbench.sv
